### rtl/ldt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ldt_pkg;

  localparam int Neurons   = 1024;
  localparam int IdxW      = 10;
  localparam int AddrMaxW  = 16;   // widest address over the NEURONS range
  localparam int IdxCmpW   = 17;   // holds NEURONS itself
  localparam int CfgW      = 16;
  localparam int CfgIdxW   = 1;

  localparam int MulAW = 33;
  localparam int MulBW = 18;
  localparam int MulPW = MulAW + MulBW;

  localparam logic [CfgW-1:0] DecayReset = 16'd62338;
  localparam logic [CfgW-1:0] ZeroReset  = 16'd100;
  localparam logic [16:0]     PowOne     = 17'h10000;   // 1.0 in Q1.16
  localparam logic [31:0]     TraceOne   = 32'h0001_0000;
  localparam logic [31:0]     TraceMax   = 32'h7fff_ffff;
  localparam logic [31:0]     TraceMin   = 32'h8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    RegDecay = 1'd0,
    RegZero  = 1'd1
  } reg_e;

  typedef enum logic [1:0] {
    OpRead      = 2'd0,
    OpAddOne    = 2'd1,
    OpAddAmount = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StPow,
    StPowWb,
    StScaleWb,
    StAdd
  } state_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [IdxW-1:0]   neuron_index;
    logic signed [31:0] amount;
    logic [31:0]       now;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] trace_value;
    logic               saturated;
  } out_word_t;

  typedef struct packed {
    logic [31:0] last_time;
    logic [31:0] trace;
  } entry_t;

  typedef struct packed {
    logic                rd_en;
    logic                wr_en;
    logic [AddrMaxW-1:0] addr;
  } store_req_t;

endpackage

`default_nettype wire

### rtl/ldt_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ldt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/ldt_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// shared signed multiplier, product registered
module ldt_mul (
  input  wire logic                                clk_i,
  input  wire logic signed [ldt_pkg::MulAW-1:0]    a_i,
  input  wire logic signed [ldt_pkg::MulBW-1:0]    b_i,
  output logic signed [ldt_pkg::MulPW-1:0]         prod_o
);

  logic signed [ldt_pkg::MulPW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### rtl/ldt_store.sv
`timescale 1ns / 1ps
`default_nettype none

// trace / last-time memory with a clearing sweep after reset
module ldt_store #(
  parameter int NEURONS = ldt_pkg::Neurons
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ldt_pkg::store_req_t  req_i,
  input  wire ldt_pkg::entry_t      wdata_i,
  output ldt_pkg::entry_t           rdata_o,
  output logic                      ready_o
);

  localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(NEURONS - 1);

  ldt_pkg::entry_t mem [NEURONS];
  ldt_pkg::entry_t rdata_q;

  logic [AW-1:0] clr_q, clr_d;
  logic          done_q, done_d;
  logic          we;
  logic [AW-1:0] waddr;
  ldt_pkg::entry_t wdata;

  always_comb begin
    clr_d  = clr_q;
    done_d = done_q;
    if (!done_q) begin
      if (clr_q == LastAddr) begin
        done_d = 1'b1;
      end else begin
        clr_d = clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      clr_q  <= clr_d;
      done_q <= done_d;
    end
  end

  assign we    = !done_q || req_i.wr_en;
  assign waddr = done_q ? req_i.addr[AW-1:0] : clr_q;
  assign wdata = done_q ? wdata_i : '0;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = done_q;

endmodule

`default_nettype wire

### rtl/lazy_decay_trace_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake      Word
// in_i     in   valid/ready    operation, neuron_index, amount, now
// out_o    out  valid/ready    trace_value, saturated
// cfg      in   cfg_we_i only  cfg_idx_i selects decay_per_tick / zero_interval
//
// One word at a time. After accept: a memory read, then each multiply on the
// shared multiplier, with a multiply state and a write-back state, then the
// same for the trace scale, then the add/write-back. For an elapsed time
// whose top set bit is k with c bits set there are c+k power multiplies; a
// kept or expired trace and an out-of-range index go from the read to the add.
// After reset the memory is swept to zero; in_i.ready is
// low during the sweep. A result waits in the output register while the
// next word is accepted; the add step stalls only if that register is full.
module lazy_decay_trace_table_unit #(
  parameter int NEURONS = ldt_pkg::Neurons
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  ldt_stream_if.sink                         in_i,
  ldt_stream_if.source                       out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [ldt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ldt_pkg::CfgW-1:0]      cfg_data_i
);

  ldt_pkg::state_e state_q, state_d;

  // config registers
  logic [ldt_pkg::CfgW-1:0] decay_q, zero_q;

  // captured word
  logic [1:0]                op_q;
  logic [ldt_pkg::IdxW-1:0]  idx_q;
  logic signed [31:0]        amount_q;
  logic [31:0]               now_q;
  logic                      oor_q;

  // working state
  logic signed [31:0] trace_q;
  logic [16:0]        pow_q;
  logic [15:0]        base_q;
  logic [15:0]        elap_q;
  logic               pmul_q;

  // result register
  logic               out_valid_q;
  ldt_pkg::out_word_t out_q;

  // memory and multiplier
  ldt_pkg::store_req_t store_req;
  ldt_pkg::entry_t     store_wdata, store_rdata;
  logic                store_ready;

  logic signed [ldt_pkg::MulAW-1:0] mul_a;
  logic signed [ldt_pkg::MulBW-1:0] mul_b;
  logic signed [ldt_pkg::MulPW-1:0] mul_p;

  logic        accept, out_free, in_range;
  logic [31:0] elapsed;
  logic signed [31:0] addend, result;
  logic signed [32:0] sum;
  logic        sat;

  ldt_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p)
  );

  ldt_store #(
    .NEURONS (NEURONS)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (store_req),
    .wdata_i (store_wdata),
    .rdata_o (store_rdata),
    .ready_o (store_ready)
  );

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_range = {{(ldt_pkg::IdxCmpW - ldt_pkg::IdxW){1'b0}}, in_i.data.neuron_index}
                    < ldt_pkg::IdxCmpW'(NEURONS);
  assign elapsed  = now_q - store_rdata.last_time;

  // add with clipping
  always_comb begin
    case (ldt_pkg::op_e'(op_q))
      ldt_pkg::OpAddOne:    addend = ldt_pkg::TraceOne;
      ldt_pkg::OpAddAmount: addend = amount_q;
      default:              addend = '0;   // read, and the unused code
    endcase
    sum = {trace_q[31], trace_q} + {addend[31], addend};
    sat = (sum[32] != sum[31]);
    if (sat) begin
      result = sum[32] ? ldt_pkg::TraceMin : ldt_pkg::TraceMax;
    end else begin
      result = sum[31:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ldt_pkg::StIdle: begin
        if (accept) state_d = ldt_pkg::StLoad;
      end
      ldt_pkg::StLoad: begin
        if (oor_q || elapsed == 32'd0 || elapsed >= {16'd0, zero_q}) begin
          state_d = ldt_pkg::StAdd;
        end else begin
          state_d = ldt_pkg::StPow;
        end
      end
      ldt_pkg::StPow: begin
        state_d = (elap_q == 16'd0) ? ldt_pkg::StScaleWb : ldt_pkg::StPowWb;
      end
      ldt_pkg::StPowWb:   state_d = ldt_pkg::StPow;
      ldt_pkg::StScaleWb: state_d = ldt_pkg::StAdd;
      ldt_pkg::StAdd: begin
        if (out_free) state_d = ldt_pkg::StIdle;
      end
      default: state_d = ldt_pkg::StIdle;
    endcase
  end

  // control outputs
  always_comb begin
    in_i.ready    = 1'b0;
    store_req     = '0;
    store_wdata   = '{last_time: now_q, trace: result};
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_q)
      ldt_pkg::StIdle: begin
        in_i.ready      = store_ready;
        store_req.rd_en = accept;
        store_req.addr  = ldt_pkg::AddrMaxW'(in_i.data.neuron_index);
      end
      ldt_pkg::StPow: begin
        if (elap_q == 16'd0) begin
          // final scale: trace * pow, floor shift later
          mul_a = {trace_q[31], trace_q};
          mul_b = {1'b0, pow_q};
        end else if (elap_q[0]) begin
          mul_a = {16'd0, pow_q};
          mul_b = {2'd0, base_q};
        end else begin
          mul_a = {17'd0, base_q};
          mul_b = {2'd0, base_q};
        end
      end
      ldt_pkg::StAdd: begin
        store_req.wr_en = out_free && !oor_q;
        store_req.addr  = ldt_pkg::AddrMaxW'(idx_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ldt_pkg::StIdle;
      decay_q     <= ldt_pkg::DecayReset;
      zero_q      <= ldt_pkg::ZeroReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (ldt_pkg::reg_e'(cfg_idx_i))
          ldt_pkg::RegDecay: decay_q <= cfg_data_i;
          ldt_pkg::RegZero:  zero_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (state_q == ldt_pkg::StAdd && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ldt_pkg::StIdle: begin
        if (accept) begin
          op_q     <= in_i.data.operation;
          idx_q    <= in_i.data.neuron_index;
          amount_q <= in_i.data.amount;
          now_q    <= in_i.data.now;
          oor_q    <= !in_range;
        end
      end
      ldt_pkg::StLoad: begin
        pow_q  <= ldt_pkg::PowOne;
        base_q <= decay_q;
        elap_q <= elapsed[15:0];
        if (oor_q || (elapsed != 32'd0 && elapsed >= {16'd0, zero_q})) begin
          trace_q <= '0;
        end else begin
          trace_q <= store_rdata.trace;
        end
      end
      ldt_pkg::StPow: begin
        pmul_q <= elap_q[0];
      end
      ldt_pkg::StPowWb: begin
        if (pmul_q) begin
          pow_q     <= mul_p[32:16];
          elap_q[0] <= 1'b0;
        end else begin
          base_q <= mul_p[31:16];
          elap_q <= {1'b0, elap_q[15:1]};
        end
      end
      ldt_pkg::StScaleWb: begin
        trace_q <= mul_p[47:16];
      end
      ldt_pkg::StAdd: begin
        if (out_free) begin
          out_q.trace_value <= oor_q ? '0 : result;
          out_q.saturated   <= oor_q ? 1'b0 : sat;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire
